// ===== src/hufd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hufd_pkg;

    // defaults for the top-level parameters
    localparam int DEF_NODE_COUNT   = 512;
    localparam int DEF_MAX_CODE_LEN = 32;

    // fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int SYMBOL_W   = 8;
    localparam int CODE_LEN_W = 6;
    localparam int CODE_W     = 32;
    localparam int CODE_IW    = $clog2(CODE_W);
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int STATUS_W   = 2;
    // clamped code length, wide enough for any MAX_CODE_LEN up to 127
    localparam int LEN_W      = 7;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SYMBOL_W-1:0] symbol;
        logic [LEN_W-1:0]    code_length;
        logic [CODE_W-1:0]   code_bits;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  bits_valid;
    } t_cmd;

    typedef struct packed {
        logic [SYMBOL_W-1:0] decoded_symbol;
        logic [STATUS_W-1:0] status;
        logic                last_of_run;
    } t_result;

endpackage

`default_nettype wire

// ===== src/hufd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hufd_front #(
    parameter int MAX_CODE_LEN = hufd_pkg::DEF_MAX_CODE_LEN
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire [hufd_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_cmd_valid,
    output hufd_pkg::t_cmd                      o_cmd,
    input  wire                                 i_cmd_pop
);

    localparam logic [hufd_pkg::QUEUE_AW:0] FULL_CNT =
        (hufd_pkg::QUEUE_AW + 1)'(hufd_pkg::QUEUE_DEPTH);
    localparam logic [hufd_pkg::LEN_W-1:0] LEN_MAX = hufd_pkg::LEN_W'(MAX_CODE_LEN);
    localparam logic [hufd_pkg::COUNT_W-1:0] CNT_MAX =
        hufd_pkg::COUNT_W'(hufd_pkg::BYTE_W);

    hufd_pkg::t_cmd                r_q [hufd_pkg::QUEUE_DEPTH];
    logic [hufd_pkg::QUEUE_AW-1:0] r_wp;
    logic [hufd_pkg::QUEUE_AW-1:0] r_rp;
    logic [hufd_pkg::QUEUE_AW:0]   r_cnt;

    hufd_pkg::t_cmd cls;
    logic [hufd_pkg::LEN_W-1:0] raw_len;
    logic           push;
    logic           pop;

    // unpack and clamp
    always_comb begin
        raw_len         = {1'b0, i_s_tdata[15:10]};
        cls.opcode      = i_s_tdata[1:0];
        cls.symbol      = i_s_tdata[9:2];
        cls.code_length = (raw_len > LEN_MAX) ? LEN_MAX : raw_len;
        cls.code_bits   = i_s_tdata[47:16];
        cls.data_byte   = i_s_tdata[55:48];
        cls.bits_valid  = (i_s_tdata[59:56] > CNT_MAX) ? CNT_MAX : i_s_tdata[59:56];
    end

    assign o_s_tready  = (r_cnt != FULL_CNT);
    // unknown opcodes are dropped here
    assign push        = i_s_tvalid && o_s_tready && (cls.opcode != hufd_pkg::OP_NONE);
    assign pop         = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{hufd_pkg::QUEUE_AW{1'b0}}, push}
                           - {{hufd_pkg::QUEUE_AW{1'b0}}, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== src/hufd_node_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hufd_node_ram #(
    parameter int DEPTH = hufd_pkg::DEF_NODE_COUNT,
    parameter int AW    = $clog2(hufd_pkg::DEF_NODE_COUNT),
    parameter int DW    = 2 * $clog2(hufd_pkg::DEF_NODE_COUNT) + hufd_pkg::SYMBOL_W
) (
    input  wire           i_clk,
    input  wire           i_we,
    input  wire  [AW-1:0] i_wa,
    input  wire  [DW-1:0] i_wd,
    input  wire           i_re,
    input  wire  [AW-1:0] i_ra,
    output logic [DW-1:0] o_rd
);

    // entry: left child, right child, symbol
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end

endmodule

`default_nettype wire

// ===== src/hufd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hufd_back #(
    parameter int NODE_COUNT = hufd_pkg::DEF_NODE_COUNT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    input  hufd_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    input  wire                  i_out_free,
    output logic                 o_push_valid,
    output hufd_pkg::t_result    o_push
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int DW = 2 * AW + hufd_pkg::SYMBOL_W;
    localparam logic [AW:0] USED_MAX = (AW + 1)'(NODE_COUNT);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_I_RD   = 9'b000000100,
        S_I_CHK  = 9'b000001000,
        S_I_LINK = 9'b000010000,
        S_D_RD   = 9'b000100000,
        S_D_CHK  = 9'b001000000,
        S_D_LEAF = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]                 r_walk, n_walk;
    logic [AW-1:0]                 r_cur, n_cur;
    logic [AW-1:0]                 r_nxt, n_nxt;
    logic [AW:0]                   r_used, n_used;
    logic [hufd_pkg::LEN_W-1:0]    r_rem, n_rem;
    logic [hufd_pkg::CODE_W-1:0]   r_code, n_code;
    logic [hufd_pkg::SYMBOL_W-1:0] r_sym, n_sym;
    logic [hufd_pkg::BYTE_W-1:0]   r_byte, n_byte;
    logic [hufd_pkg::COUNT_W-1:0]  r_cnt, n_cnt;
    logic                          r_pend_v, n_pend_v;
    logic [hufd_pkg::SYMBOL_W-1:0] r_pend_sym, n_pend_sym;
    logic [hufd_pkg::STATUS_W-1:0] r_pend_st, n_pend_st;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [DW-1:0] mem_wd, mem_rd;

    logic [AW-1:0]                 rd_left, rd_right;
    logic [hufd_pkg::SYMBOL_W-1:0] rd_sym;
    logic [hufd_pkg::LEN_W-1:0]    pos;
    logic                          code_bit;
    logic [AW-1:0]                 slot;
    logic [AW-1:0]                 dnxt;
    logic                          can_emit;
    logic                          emit;
    logic [hufd_pkg::SYMBOL_W-1:0] emit_sym;
    logic [hufd_pkg::STATUS_W-1:0] emit_st;

    hufd_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    assign rd_left  = mem_rd[DW-1:AW+hufd_pkg::SYMBOL_W];
    assign rd_right = mem_rd[AW+hufd_pkg::SYMBOL_W-1:hufd_pkg::SYMBOL_W];
    assign rd_sym   = mem_rd[hufd_pkg::SYMBOL_W-1:0];

    // code bit at position rem-1, positions past the code word read as 0
    assign pos      = r_rem - 1'b1;
    assign code_bit = (pos < hufd_pkg::LEN_W'(hufd_pkg::CODE_W)) ?
                      r_code[pos[hufd_pkg::CODE_IW-1:0]] : 1'b0;
    assign slot     = code_bit ? rd_right : rd_left;
    assign dnxt     = r_byte[hufd_pkg::BYTE_W-1] ? rd_right : rd_left;

    // a new result parks in the pending slot, pushing the old one out
    assign can_emit = !r_pend_v || i_out_free;

    always_comb begin
        n_state    = r_state;
        n_walk     = r_walk;
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_used     = r_used;
        n_rem      = r_rem;
        n_code     = r_code;
        n_sym      = r_sym;
        n_byte     = r_byte;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        o_cmd_pop  = 1'b0;
        emit       = 1'b0;
        emit_sym   = '0;
        emit_st    = hufd_pkg::ST_SYMBOL;

        unique case (r_state)
            S_INIT: begin
                // root gets no children
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.opcode)
                        hufd_pkg::OP_CLEAR: begin
                            mem_we = 1'b1;
                            n_used = (AW + 1)'(1);
                            n_walk = '0;
                        end
                        hufd_pkg::OP_INSERT: begin
                            n_cur   = '0;
                            n_rem   = i_cmd.code_length;
                            n_code  = i_cmd.code_bits;
                            n_sym   = i_cmd.symbol;
                            n_state = S_I_RD;
                        end
                        hufd_pkg::OP_DECODE: begin
                            n_byte  = i_cmd.data_byte;
                            n_cnt   = i_cmd.bits_valid;
                            n_state = (i_cmd.bits_valid == '0) ? S_FLUSH : S_D_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_I_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_cur;
                n_state = S_I_CHK;
            end
            S_I_CHK: begin
                if (r_rem == '0) begin
                    // end of path: keep children, store symbol
                    mem_we  = 1'b1;
                    mem_wa  = r_cur;
                    mem_wd  = {rd_left, rd_right, r_sym};
                    n_state = S_FLUSH;
                end else if (slot != '0) begin
                    n_cur   = slot;
                    n_rem   = r_rem - 1'b1;
                    n_state = S_I_RD;
                end else if (r_used == USED_MAX) begin
                    emit    = 1'b1;
                    emit_st = hufd_pkg::ST_FULL;
                    n_state = can_emit ? S_FLUSH : S_I_CHK;
                end else begin
                    // allocate a fresh node
                    mem_we  = 1'b1;
                    mem_wa  = r_used[AW-1:0];
                    n_nxt   = r_used[AW-1:0];
                    n_state = S_I_LINK;
                end
            end
            S_I_LINK: begin
                mem_we  = 1'b1;
                mem_wa  = r_cur;
                mem_wd  = code_bit ? {rd_left, r_nxt, rd_sym} : {r_nxt, rd_right, rd_sym};
                n_cur   = r_nxt;
                n_used  = r_used + 1'b1;
                n_rem   = r_rem - 1'b1;
                n_state = S_I_RD;
            end
            S_D_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_walk;
                n_state = S_D_CHK;
            end
            S_D_CHK: begin
                if (r_cnt == '0) begin
                    n_state = S_FLUSH;
                end else if (dnxt == '0) begin
                    // missing branch drops the rest of the byte
                    emit    = 1'b1;
                    emit_st = hufd_pkg::ST_MISSING;
                    if (can_emit) begin
                        n_walk  = '0;
                        n_state = S_FLUSH;
                    end
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = dnxt;
                    n_nxt   = dnxt;
                    n_state = S_D_LEAF;
                end
            end
            S_D_LEAF: begin
                if (rd_left == '0 && rd_right == '0) begin
                    emit     = 1'b1;
                    emit_sym = rd_sym;
                    if (can_emit) begin
                        n_walk  = '0;
                        n_byte  = {r_byte[hufd_pkg::BYTE_W-2:0], 1'b0};
                        n_cnt   = r_cnt - 1'b1;
                        n_state = (r_cnt == hufd_pkg::COUNT_W'(1)) ? S_FLUSH : S_D_RD;
                    end
                end else begin
                    // interior node: its children are already in the read register
                    n_walk  = r_nxt;
                    n_byte  = {r_byte[hufd_pkg::BYTE_W-2:0], 1'b0};
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_D_CHK;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // pending result and push toward the output register
    always_comb begin
        n_pend_v     = r_pend_v;
        n_pend_sym   = r_pend_sym;
        n_pend_st    = r_pend_st;
        o_push_valid = 1'b0;
        o_push       = '{decoded_symbol: r_pend_sym, status: r_pend_st, last_of_run: 1'b0};
        if (emit && can_emit) begin
            o_push_valid = r_pend_v;
            n_pend_v     = 1'b1;
            n_pend_sym   = emit_sym;
            n_pend_st    = emit_st;
        end else if (r_state == S_FLUSH) begin
            o_push_valid       = r_pend_v && i_out_free;
            o_push.last_of_run = 1'b1;
            if (i_out_free) begin
                n_pend_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_walk   <= '0;
            r_used   <= (AW + 1)'(1);
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_used   <= n_used;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_rem      <= n_rem;
        r_code     <= n_code;
        r_sym      <= n_sym;
        r_byte     <= n_byte;
        r_cnt      <= n_cnt;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
    end

endmodule

`default_nettype wire

// ===== src/huffman_tree_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// huffman tree-walk decoder
// input stream (s side): one command per transfer; clear tree, insert a code or
//   decode a byte; opcode 3 is accepted and dropped
// output stream (m side): decoded symbols and error results; tlast marks the
//   final result of one command, tuser carries the status
// structure: a front end classifies and clamps commands into a two-entry queue,
//   a back end sequencer walks a node table held in a single-port-write,
//   registered-read memory
// sequencing: bound by the node memory read; every command is first dispatched
//   from idle; a decode then reads the current node for the first bit and for
//   each bit following a leaf, checks the branch and reads the child for every
//   bit, checks again when the last bit ends on an inner node, and closes in
//   flush; an insert reads and checks each node on the code path, writes a link
//   for each newly allocated node, then stores the symbol and flushes; clear ends at dispatch
// holding: a symbol waits in the pending slot until the next result or the end
//   of its command is known, then passes on to the output register
// reset: the queue and output empty, the tree is cleared (the root is written
//   in the init state before the first command starts)
// stalls: the output register is taken independent of the sequencer; when it
//   stays full the walk waits, the queue fills and s_tready falls
module huffman_tree_decoder #(
    parameter int NODE_COUNT   = hufd_pkg::DEF_NODE_COUNT,
    parameter int MAX_CODE_LEN = hufd_pkg::DEF_MAX_CODE_LEN
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // opcode, symbol, code_length, code_bits, data_byte, bits_valid, zero fill
    input  wire  [hufd_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // decoded_symbol
    output logic [hufd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // status
    output logic [hufd_pkg::STATUS_W-1:0]        o_m_tuser,
    output logic                                 o_m_tlast
);

    logic              cmd_valid;
    hufd_pkg::t_cmd    cmd;
    logic              cmd_pop;
    logic              out_free;
    logic              push_valid;
    hufd_pkg::t_result push;

    logic              r_out_v;
    hufd_pkg::t_result r_out;

    hufd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    hufd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .i_out_free   (out_free),
        .o_push_valid (push_valid),
        .o_push       (push)
    );

    // output register: refilled in the same cycle it is drained
    assign out_free = !r_out_v || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push_valid) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_valid) begin
            r_out <= push;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out.decoded_symbol;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last_of_run;

    // the back end only hands over a result when the output register can take it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> out_free)
        else $error("result pushed into a full output register");

    // error results carry a zero symbol
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != hufd_pkg::ST_SYMBOL) |-> (o_m_tdata == '0))
        else $error("error result with nonzero symbol");

    // an error ends its command, so it is always the last result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == hufd_pkg::ST_MISSING ||
                        o_m_tuser == hufd_pkg::ST_FULL)) |-> o_m_tlast)
        else $error("error result not marked last");

    // a pop only happens when the queue has an entry
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES          = hufd_pkg::DEF_NODE_COUNT;
    localparam int CODE_MAX       = hufd_pkg::DEF_MAX_CODE_LEN;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TREE_DEPTH_MAX = 12;
    localparam int LONG_HOLD      = 300;

    // one command as it travels on the input stream, opcode in the lowest bits
    typedef struct packed {
        logic [hufd_pkg::COUNT_W-1:0]    bits_valid;
        logic [hufd_pkg::BYTE_W-1:0]     data_byte;
        logic [hufd_pkg::CODE_W-1:0]     code_bits;
        logic [hufd_pkg::CODE_LEN_W-1:0] code_length;
        logic [hufd_pkg::SYMBOL_W-1:0]   symbol;
        logic [hufd_pkg::OPCODE_W-1:0]   opcode;
    } t_item;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic [hufd_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                             i_m_tready = 1'b0;
    wire                              o_s_tready;
    wire                              o_m_tvalid;
    wire  [hufd_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    wire  [hufd_pkg::STATUS_W-1:0]    o_m_tuser;
    wire                              o_m_tlast;

    huffman_tree_decoder #(
        .NODE_COUNT   (NODES),
        .MAX_CODE_LEN (CODE_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predicted tree state
    logic [8:0]                    tree_left   [NODES];
    logic [8:0]                    tree_right  [NODES];
    logic [hufd_pkg::SYMBOL_W-1:0] node_symbol [NODES];
    int                            nodes_alloc;
    logic [8:0]                    walk_pos;

    hufd_pkg::t_result pending_results [$];
    int          fail_count     = 0;
    int          items_sent     = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    int          rx_hold_request = 0;
    int          rx_hold_left   = 0;
    int          quiet_cycles   = 0;

    // leaves of the current prefix code
    int unsigned leaf_code [$];
    int          leaf_len  [$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // works out the results of one accepted command and updates the predicted tree
    task automatic predict_item(t_item item);
        hufd_pkg::t_result run_results [$];
        hufd_pkg::t_result res;
        int           len;
        int           cnt;
        logic [8:0]   cur;
        logic [8:0]   nxt;
        logic         b;
        bit           stopped;
        stopped = 1'b0;
        case (item.opcode)
            hufd_pkg::OP_CLEAR: begin
                tree_left[0]  = '0;
                tree_right[0] = '0;
                nodes_alloc   = 1;
                walk_pos      = '0;
            end
            hufd_pkg::OP_INSERT: begin
                len = (item.code_length > CODE_MAX) ? CODE_MAX : item.code_length;
                cur = '0;
                // walk the code path from the root, allocating missing children
                for (int i = len; i > 0 && !stopped; i--) begin
                    b   = (i - 1 < hufd_pkg::CODE_W) ? item.code_bits[i-1] : 1'b0;
                    nxt = b ? tree_right[cur] : tree_left[cur];
                    if (nxt == '0) begin
                        if (nodes_alloc >= NODES) begin
                            res.decoded_symbol = '0;
                            res.status         = hufd_pkg::ST_FULL;
                            res.last_of_run    = 1'b0;
                            run_results.insert(run_results.size(), res);
                            stopped = 1'b1;
                        end else begin
                            nxt = 9'(nodes_alloc);
                            nodes_alloc++;
                            tree_left[nxt]   = '0;
                            tree_right[nxt]  = '0;
                            node_symbol[nxt] = '0;
                            if (b) tree_right[cur] = nxt;
                            else   tree_left[cur]  = nxt;
                        end
                    end
                    if (!stopped) cur = nxt;
                end
                if (!stopped) node_symbol[cur] = item.symbol;
            end
            hufd_pkg::OP_DECODE: begin
                cnt = (item.bits_valid > hufd_pkg::BYTE_W) ? hufd_pkg::BYTE_W
                                                           : item.bits_valid;
                for (int j = 0; j < cnt && !stopped; j++) begin
                    b   = item.data_byte[hufd_pkg::BYTE_W-1-j];
                    nxt = b ? tree_right[walk_pos] : tree_left[walk_pos];
                    if (nxt == '0) begin
                        // missing branch drops the rest of the byte
                        res.decoded_symbol = '0;
                        res.status         = hufd_pkg::ST_MISSING;
                        res.last_of_run    = 1'b0;
                        run_results.insert(run_results.size(), res);
                        walk_pos = '0;
                        stopped  = 1'b1;
                    end else if (tree_left[nxt] == '0 && tree_right[nxt] == '0) begin
                        res.decoded_symbol = node_symbol[nxt];
                        res.status         = hufd_pkg::ST_SYMBOL;
                        res.last_of_run    = 1'b0;
                        run_results.insert(run_results.size(), res);
                        walk_pos = '0;
                    end else begin
                        walk_pos = nxt;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < run_results.size(); k++) begin
            res = run_results[k];
            res.last_of_run = (k == run_results.size() - 1);
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // offers one command, waits for its transfer, then predicts it
    task automatic send_item(t_item item);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= hufd_pkg::IN_TDATA_W'(item);
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        predict_item(item);
        if (item.opcode != hufd_pkg::OP_NONE) items_sent++;
    endtask

    // unused fields carry random values so every command field bit moves
    function automatic t_item make_clear();
        t_item item;
        item.opcode      = hufd_pkg::OP_CLEAR;
        item.symbol      = hufd_pkg::SYMBOL_W'($urandom);
        item.code_length = hufd_pkg::CODE_LEN_W'($urandom);
        item.code_bits   = $urandom;
        item.data_byte   = hufd_pkg::BYTE_W'($urandom);
        item.bits_valid  = hufd_pkg::COUNT_W'($urandom);
        return item;
    endfunction

    function automatic t_item make_insert(int sym, int len, logic [31:0] code);
        t_item item;
        item             = make_clear();
        item.opcode      = hufd_pkg::OP_INSERT;
        item.symbol      = hufd_pkg::SYMBOL_W'(sym);
        item.code_length = hufd_pkg::CODE_LEN_W'(len);
        item.code_bits   = code;
        return item;
    endfunction

    function automatic t_item make_decode(int data, int cnt);
        t_item item;
        item            = make_clear();
        item.opcode     = hufd_pkg::OP_DECODE;
        item.data_byte  = hufd_pkg::BYTE_W'(data);
        item.bits_valid = hufd_pkg::COUNT_W'(cnt);
        return item;
    endfunction

    // clears the tree and inserts a random complete prefix code, one leaf
    // optionally left out so the walk can hit a missing branch
    task automatic build_code_set(int splits, bit drop_one);
        int          pick;
        int          drop_idx;
        int unsigned c;
        int          l;
        leaf_code = {0};
        leaf_len  = {0};
        repeat (splits) begin
            pick = $urandom_range(leaf_code.size() - 1);
            if (leaf_len[pick] < TREE_DEPTH_MAX) begin
                c = leaf_code[pick];
                l = leaf_len[pick];
                leaf_code[pick] = c << 1;
                leaf_len[pick]  = l + 1;
                leaf_code.insert(leaf_code.size(), (c << 1) | 1);
                leaf_len.insert(leaf_len.size(), l + 1);
            end
        end
        drop_idx = drop_one ? $urandom_range(leaf_code.size() - 1) : -1;
        send_item(make_clear());
        for (int k = 0; k < leaf_code.size(); k++) begin
            if (k != drop_idx) begin
                send_item(make_insert($urandom_range(255), leaf_len[k],
                                      ($urandom << leaf_len[k]) | leaf_code[k]));
            end
        end
    endtask

    // encodes random leaves into a bit stream and feeds it in byte chunks
    task automatic send_message(int n_syms, bit broken);
        bit         stream [$];
        int         pick;
        int         chunk;
        int         cnt;
        logic [7:0] byte_val;
        repeat (n_syms) begin
            pick = $urandom_range(leaf_code.size() - 1);
            for (int b = leaf_len[pick] - 1; b >= 0; b--)
                stream.insert(stream.size(), bit'((leaf_code[pick] >> b) & 1));
        end
        if (broken) begin
            repeat ($urandom_range(1, 10))
                stream.insert(stream.size(), bit'($urandom_range(1)));
        end
        while (stream.size() != 0) begin
            chunk = ($urandom_range(99) < 70) ? 8 : $urandom_range(1, 8);
            if (chunk > stream.size()) chunk = stream.size();
            byte_val = 8'($urandom);
            for (int k = 0; k < chunk; k++) byte_val[7-k] = stream.pop_front();
            cnt = chunk;
            // counts above eight act as eight
            if (chunk == 8 && $urandom_range(99) < 20) cnt = $urandom_range(8, 15);
            send_item(make_decode(byte_val, cnt));
        end
    endtask

    task automatic send_noise(int n);
        t_item item;
        repeat (n) begin
            item             = make_clear();
            item.opcode      = hufd_pkg::OPCODE_W'($urandom_range(3));
            item.code_length = hufd_pkg::CODE_LEN_W'($urandom_range(63));
            item.bits_valid  = hufd_pkg::COUNT_W'($urandom_range(15));
            send_item(item);
        end
    endtask

    task automatic test_basic_ops();
        t_item item;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        item        = make_clear();
        item.opcode = hufd_pkg::OP_NONE;
        send_item(item);                                  // dropped opcode
        send_item(make_decode(8'h00, 8));                 // empty tree, missing branch
        send_item(make_decode(8'hFF, 0));                 // zero bits, no result
        send_item(make_insert(8'h5A, 0, $urandom));       // empty code lands on the root
        send_item(make_decode(8'h80, 8));                 // root is never emitted
        send_item(make_insert(8'h00, 1, 32'hFFFF_FFFE));
        send_item(make_insert(8'hFF, 1, 32'hFFFF_FFFF));
        send_item(make_decode(8'hA5, 8));                 // eight symbols from one byte
        send_item(make_decode(8'h3C, 15));                // count clamped to eight
        send_item(make_decode(8'hE0, 3));
        send_item(make_insert(8'h11, 2, 32'h0000_0001));  // leaf "0" gains a child
        send_item(make_decode(8'h00, 1));                 // walk parks on an inner node
        send_item(make_insert(8'h22, 3, 32'h0000_0007));  // insert leaves the walk alone
        send_item(make_decode(8'h80, 1));
        send_item(make_decode(8'h00, 8));
        send_item(make_insert(8'h33, 63, 32'hFFFF_FFFF)); // length clamped to the max
        send_item(make_insert(8'h44, 40, 32'h7FFF_FFFF));
        repeat (4) send_item(make_decode(8'hFF, 8));
        send_item(make_decode(8'h7F, 8));
        repeat (3) send_item(make_decode(8'hFF, 8));
        send_item(make_clear());
        send_item(make_decode(8'h55, 8));
    endtask

    // long random codes until the node table runs out
    task automatic test_table_full();
        tx_idle_pct  = 27;
        rx_stall_pct = 27;
        send_item(make_clear());
        repeat (20) send_item(make_insert($urandom_range(255), 32, $urandom));
        repeat (6) send_item(make_decode($urandom_range(255), 8));
        send_item(make_insert($urandom_range(255), 1, $urandom));
    endtask

    // receiver holds off while many results pile up behind it
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        build_code_set(1, 1'b0);
        rx_hold_request = LONG_HOLD;
        repeat (20) send_item(make_decode($urandom_range(255), 8));
    endtask

    // sender stops until everything predicted has come out
    task automatic test_drain_pause();
        tx_idle_pct  = 0;
        rx_stall_pct = 27;
        build_code_set($urandom_range(3, 10), 1'b0);
        send_message(10, 1'b0);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        send_message(10, 1'b0);
    endtask

    task automatic test_random(int goal, int tx_pct, int rx_pct);
        int target;
        int r;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target       = items_sent + goal;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 80) begin
                build_code_set($urandom_range(1, 15), 1'b0);
                send_message($urandom_range(3, 25), 1'b0);
            end else if (r < 90) begin
                build_code_set($urandom_range(1, 15), 1'b1);
                send_message($urandom_range(3, 25), 1'b1);
            end else begin
                send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // receiver ready, random stalls plus the long hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // outputs are sampled mid-cycle, a transfer then completes at the next rising edge
    always @(negedge i_clk) begin
        hufd_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result symbol", o_m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata != want.decoded_symbol)
                    report_mismatch("decoded_symbol", o_m_tdata, want.decoded_symbol);
                if (o_m_tuser != want.status)
                    report_mismatch("status", o_m_tuser, want.status);
                if (o_m_tlast != want.last_of_run)
                    report_mismatch("last_of_run", o_m_tlast, want.last_of_run);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("huffman_tree_decoder verification failed");
                $finish;
            end
        end
    end

    initial begin
        for (int n = 0; n < NODES; n++) begin
            tree_left[n]   = '0;
            tree_right[n]  = '0;
            node_symbol[n] = '0;
        end
        nodes_alloc = 1;
        walk_pos    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_table_full();
        test_backpressure();
        test_drain_pause();
        test_random(90, 0, 0);
        test_random(80, 53, 0);
        test_random(80, 0, 53);
        test_random(80, 27, 27);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("huffman_tree_decoder verification clean");
        else
            $display("huffman_tree_decoder verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hufd_pkg.sv
src/hufd_front.sv
src/hufd_node_ram.sv
src/hufd_back.sv
src/huffman_tree_decoder.sv
test/tb_top.sv
